// ===== hw/rtl/cqps_pkg.sv =====
// Shared constants and types for the quadratic curve point sampler.
`timescale 1ns / 1ps
package cqps_pkg;

   localparam int INDEX_W  = 14;
   localparam int STEP_W   = 14;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int NUM_REGS = 6;

   localparam logic [2:0] REG_CTRL0_X = 3'd0;
   localparam logic [2:0] REG_CTRL0_Y = 3'd1;
   localparam logic [2:0] REG_CTRL1_X = 3'd2;
   localparam logic [2:0] REG_CTRL1_Y = 3'd3;
   localparam logic [2:0] REG_CTRL2_X = 3'd4;
   localparam logic [2:0] REG_CTRL2_Y = 3'd5;

   typedef struct packed {
      logic              in_range;
      logic [STEP_W-1:0] step_total;
   } side_type;

endpackage

// ===== hw/rtl/quadratic_curve_point_sampler_core.sv =====
// Top level: register file, index stages, term unit, divider and result register.
//
//  channel   ports                               direction  handshake
//  request   start, busy, req_sample_index        in         start && !busy
//  result    rsp_valid, rsp_point_x/y, ...        out        rsp_valid, one cycle
//  config    psel, penable, pwrite, paddr, ...    in/out     APB, pready tied high
//
// One sample is taken every cycle while busy is low; the divider yields one quotient bit
// per stage. busy is high only during and just after reset. Results are strobed for a
// single cycle and cannot be held off; nothing in the pipeline stalls. Reset clears the
// valid bits and the control registers.
`timescale 1ns / 1ps
module quadratic_curve_point_sampler_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cqps_pkg::INDEX_W-1:0]  req_sample_index,
   output logic                          rsp_valid,
   output logic [COORD_BITS-1:0]         rsp_point_x,
   output logic [COORD_BITS-1:0]         rsp_point_y,
   output logic [cqps_pkg::STEP_W-1:0]   rsp_step_total,
   output logic                          rsp_in_range,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cqps_pkg::ADDR_W-1:0]   paddr,
   input  logic [cqps_pkg::DATA_W-1:0]   pwdata,
   output logic [cqps_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import cqps_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int NW = CB + 2;
   localparam int CW = (NW > INDEX_W) ? NW : INDEX_W;
   localparam int DW = 2*NW + CB;

   // configuration registers
   logic [CB-1:0] p0x_ff, p0y_ff, p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic          wr_en;
   logic [2:0]    wr_idx;
   logic          busy_ff;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         p0x_ff <= '0; p0y_ff <= '0;
         p1x_ff <= '0; p1y_ff <= '0;
         p2x_ff <= '0; p2y_ff <= '0;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_CTRL0_X: p0x_ff <= pwdata[CB-1:0];
            REG_CTRL0_Y: p0y_ff <= pwdata[CB-1:0];
            REG_CTRL1_X: p1x_ff <= pwdata[CB-1:0];
            REG_CTRL1_Y: p1y_ff <= pwdata[CB-1:0];
            REG_CTRL2_X: p2x_ff <= pwdata[CB-1:0];
            REG_CTRL2_Y: p2y_ff <= pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_idx)
         REG_CTRL0_X: prdata = DATA_W'(p0x_ff);
         REG_CTRL0_Y: prdata = DATA_W'(p0y_ff);
         REG_CTRL1_X: prdata = DATA_W'(p1x_ff);
         REG_CTRL1_Y: prdata = DATA_W'(p1y_ff);
         REG_CTRL2_X: prdata = DATA_W'(p2x_ff);
         REG_CTRL2_Y: prdata = DATA_W'(p2y_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff | reset;

   // step total from the bounding box, refreshed every cycle
   function automatic logic [CB-1:0] span3(logic [CB-1:0] a, logic [CB-1:0] b,
                                           logic [CB-1:0] c);
      logic [CB-1:0] lo, hi;
      lo = a; hi = a;
      if (b < lo) lo = b;
      if (c < lo) lo = c;
      if (b > hi) hi = b;
      if (c > hi) hi = c;
      return hi - lo;
   endfunction

   logic [NW-1:0] n_ff, n_in;
   assign n_in = {(CB+1)'(span3(p0x_ff, p1x_ff, p2x_ff))
                  + (CB+1)'(span3(p0y_ff, p1y_ff, p2y_ff)), 1'b0};
   always_ff @(posedge clock) begin
      n_ff <= n_in;
   end

   // stage A: capture the beat
   logic               a_valid_ff;
   logic [INDEX_W-1:0] a_s_ff;
   // stage B: range check and complement
   logic               b_valid_ff;
   side_type           b_side_ff;
   logic [NW-1:0]      b_s_ff, b_r_ff, b_n_ff;
   // stage C: squares and cross term
   logic               c_valid_ff;
   side_type           c_side_ff;
   logic [2*NW-1:0]    c_rr_ff, c_ss_ff, c_den_ff;
   logic [2*NW:0]      c_sr2_ff;

   logic [CW-1:0]      s_wide, n_wide;
   side_type           b_side_in;

   assign s_wide = CW'(a_s_ff);
   assign n_wide = CW'(n_ff);
   assign b_side_in.in_range   = s_wide < n_wide;
   assign b_side_in.step_total = n_wide[STEP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_s_ff    <= req_sample_index;
      b_side_ff <= b_side_in;
      b_s_ff    <= s_wide[NW-1:0];
      b_r_ff    <= n_ff - s_wide[NW-1:0];
      b_n_ff    <= n_ff;
      c_side_ff <= b_side_ff;
      c_rr_ff   <= b_r_ff * b_r_ff;
      c_ss_ff   <= b_s_ff * b_s_ff;
      c_sr2_ff  <= {(2*NW)'(b_s_ff) * (2*NW)'(b_r_ff), 1'b0};
      c_den_ff  <= b_n_ff * b_n_ff;
   end

   logic            t_valid;
   side_type        t_side;
   logic [DW-1:0]   t_num_x, t_num_y;
   logic [2*NW-1:0] t_den;

   cqps_terms #(.CB(CB), .NW(NW)) u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_side   (c_side_ff),
      .in_rr     (c_rr_ff),
      .in_sr2    (c_sr2_ff),
      .in_ss     (c_ss_ff),
      .in_den    (c_den_ff),
      .p0x       (p0x_ff),
      .p0y       (p0y_ff),
      .p1x       (p1x_ff),
      .p1y       (p1y_ff),
      .p2x       (p2x_ff),
      .p2y       (p2y_ff),
      .out_valid (t_valid),
      .out_side  (t_side),
      .out_num_x (t_num_x),
      .out_num_y (t_num_y),
      .out_den   (t_den)
   );

   logic          q_valid;
   side_type      q_side;
   logic [CB-1:0] q_x, q_y;

   cqps_div #(.CB(CB), .NW(NW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .in_side   (t_side),
      .in_num_x  (t_num_x),
      .in_num_y  (t_num_y),
      .in_den    (t_den),
      .out_valid (q_valid),
      .out_side  (q_side),
      .out_q_x   (q_x),
      .out_q_y   (q_y)
   );

   // result register: zero the point when out of range
   logic              o_valid_ff;
   logic [CB-1:0]     o_x_ff, o_y_ff;
   logic [STEP_W-1:0] o_n_ff;
   logic              o_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      o_x_ff  <= q_side.in_range ? q_x : '0;
      o_y_ff  <= q_side.in_range ? q_y : '0;
      o_n_ff  <= q_side.step_total;
      o_ok_ff <= q_side.in_range;
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_point_x    = o_x_ff;
   assign rsp_point_y    = o_y_ff;
   assign rsp_step_total = o_n_ff;
   assign rsp_in_range   = o_ok_ff;

   a_zero_when_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_point_x == '0 && rsp_point_y == '0)
      else $error("out-of-range beat carries a non-zero point");

   a_flush_on_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_busy_only_reset: assert property (@(posedge clock)
      !reset && $past(!reset) |-> !busy)
      else $error("busy raised outside reset");

endmodule

// ===== hw/rtl/cqps_terms.sv =====
// Weighting of the control coordinates and the rounded dividend sum.
`timescale 1ns / 1ps
module cqps_terms #(
   parameter int CB = 12,
   parameter int NW = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  cqps_pkg::side_type     in_side,
   input  logic [2*NW-1:0]        in_rr,
   input  logic [2*NW:0]          in_sr2,
   input  logic [2*NW-1:0]        in_ss,
   input  logic [2*NW-1:0]        in_den,
   input  logic [CB-1:0]          p0x,
   input  logic [CB-1:0]          p0y,
   input  logic [CB-1:0]          p1x,
   input  logic [CB-1:0]          p1y,
   input  logic [CB-1:0]          p2x,
   input  logic [CB-1:0]          p2y,
   output logic                   out_valid,
   output cqps_pkg::side_type     out_side,
   output logic [2*NW+CB-1:0]     out_num_x,
   output logic [2*NW+CB-1:0]     out_num_y,
   output logic [2*NW-1:0]        out_den
);
   import cqps_pkg::*;

   localparam int DW   = 2*NW + CB;
   localparam int SUMW = DW + 2;

   logic              d_valid_ff;
   side_type          d_side_ff;
   logic [DW-1:0]     d_t0x_ff, d_t0y_ff, d_t2x_ff, d_t2y_ff;
   logic [DW:0]       d_t1x_ff, d_t1y_ff;
   logic [2*NW-1:0]   d_den_ff;

   logic              e_valid_ff;
   side_type          e_side_ff;
   logic [DW-1:0]     e_num_x_ff, e_num_y_ff;
   logic [2*NW-1:0]   e_den_ff;

   logic [SUMW-1:0]   sum_x_in, sum_y_in, half_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= in_valid;
         e_valid_ff <= d_valid_ff;
      end
   end

   // one multiplier per term, registered before the sum
   always_ff @(posedge clock) begin
      d_side_ff <= in_side;
      d_den_ff  <= in_den;
      d_t0x_ff  <= in_rr * p0x;
      d_t0y_ff  <= in_rr * p0y;
      d_t1x_ff  <= in_sr2 * p1x;
      d_t1y_ff  <= in_sr2 * p1y;
      d_t2x_ff  <= in_ss * p2x;
      d_t2y_ff  <= in_ss * p2y;
   end

   // step total is even, so half the denominator is exact
   assign half_den = SUMW'(d_den_ff >> 1);
   assign sum_x_in = SUMW'(d_t0x_ff) + SUMW'(d_t1x_ff) + SUMW'(d_t2x_ff) + half_den;
   assign sum_y_in = SUMW'(d_t0y_ff) + SUMW'(d_t1y_ff) + SUMW'(d_t2y_ff) + half_den;

   always_ff @(posedge clock) begin
      e_side_ff  <= d_side_ff;
      e_den_ff   <= d_den_ff;
      e_num_x_ff <= sum_x_in[DW-1:0];
      e_num_y_ff <= sum_y_in[DW-1:0];
   end

   assign out_valid = e_valid_ff;
   assign out_side  = e_side_ff;
   assign out_num_x = e_num_x_ff;
   assign out_num_y = e_num_y_ff;
   assign out_den   = e_den_ff;

endmodule

// ===== hw/rtl/cqps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for both coordinates.
`timescale 1ns / 1ps
module cqps_div #(
   parameter int CB = 12,
   parameter int NW = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  cqps_pkg::side_type     in_side,
   input  logic [2*NW+CB-1:0]     in_num_x,
   input  logic [2*NW+CB-1:0]     in_num_y,
   input  logic [2*NW-1:0]        in_den,
   output logic                   out_valid,
   output cqps_pkg::side_type     out_side,
   output logic [CB-1:0]          out_q_x,
   output logic [CB-1:0]          out_q_y
);
   import cqps_pkg::*;

   localparam int DW = 2*NW + CB;

   logic              valid_ff [CB+1];
   side_type          side_ff  [CB+1];
   logic [DW-1:0]     rem_x_ff [CB+1];
   logic [DW-1:0]     rem_y_ff [CB+1];
   logic [CB-1:0]     q_x_ff   [CB+1];
   logic [CB-1:0]     q_y_ff   [CB+1];
   logic [2*NW-1:0]   den_ff   [CB+1];

   always_comb begin
      valid_ff[0] = in_valid;
      side_ff[0]  = in_side;
      rem_x_ff[0] = in_num_x;
      rem_y_ff[0] = in_num_y;
      q_x_ff[0]   = '0;
      q_y_ff[0]   = '0;
      den_ff[0]   = in_den;
   end

   for (genvar k = 0; k < CB; k++) begin : g_stage
      localparam int BIT = CB - 1 - k;
      logic [DW-1:0] trial;
      logic          take_x, take_y;

      assign trial  = DW'(den_ff[k]) << BIT;
      assign take_x = rem_x_ff[k] >= trial;
      assign take_y = rem_y_ff[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         side_ff[k+1]  <= side_ff[k];
         den_ff[k+1]   <= den_ff[k];
         rem_x_ff[k+1] <= take_x ? rem_x_ff[k] - trial : rem_x_ff[k];
         rem_y_ff[k+1] <= take_y ? rem_y_ff[k] - trial : rem_y_ff[k];
         q_x_ff[k+1]   <= q_x_ff[k] | (CB'(take_x) << BIT);
         q_y_ff[k+1]   <= q_y_ff[k] | (CB'(take_y) << BIT);
      end
   end

   assign out_valid = valid_ff[CB];
   assign out_side  = side_ff[CB];
   assign out_q_x   = q_x_ff[CB];
   assign out_q_y   = q_y_ff[CB];

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the quadratic curve point sampler: table, then random samples.
`timescale 1ns / 1ps
module tb;
   import cqps_pkg::*;

   localparam int CB = 12;
   localparam int LATENCY = CB + 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [INDEX_W-1:0] req_sample_index = '0;
   logic rsp_valid;
   logic [CB-1:0] rsp_point_x, rsp_point_y;
   logic [STEP_W-1:0] rsp_step_total;
   logic rsp_in_range;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   typedef struct packed {
      logic [CB-1:0]     px;
      logic [CB-1:0]     py;
      logic [STEP_W-1:0] steps;
      logic              ok;
   } point_type;

   typedef struct {
      logic [INDEX_W-1:0] s;
      logic               typed;
      point_type          want;
   } row_type;

   point_type pending_points[$];
   logic [CB-1:0] ctrl[NUM_REGS];
   int mismatches = 0;
   int idle_pct = 0;

   quadratic_curve_point_sampler_core #(.COORD_BITS(CB)) dut (.*);

   always #6 clock = ~clock;

   function automatic logic [STEP_W+1:0] span_of(input logic [CB-1:0] a, b, c);
      logic [CB-1:0] lo, hi;
      lo = a; hi = a;
      if (b < lo) lo = b;
      if (c < lo) lo = c;
      if (b > hi) hi = b;
      if (c > hi) hi = c;
      return hi - lo;
   endfunction

   function automatic logic [CB-1:0] curve_coord(input logic [CB-1:0] p0, p1, p2,
                                                 input longint s, n);
      longint r, den, num;
      r = n - s;
      den = n * n;
      num = r * r * p0 + 2 * s * r * p1 + s * s * p2;
      return CB'((2 * num + den) / (2 * den));
   endfunction

   function automatic point_type sample_point(input logic [INDEX_W-1:0] s);
      point_type p;
      longint n;
      n = 2 * (longint'(span_of(ctrl[REG_CTRL0_X], ctrl[REG_CTRL1_X], ctrl[REG_CTRL2_X]))
             + longint'(span_of(ctrl[REG_CTRL0_Y], ctrl[REG_CTRL1_Y], ctrl[REG_CTRL2_Y])));
      p = '0;
      p.steps = STEP_W'(n);
      if (s < n) begin
         p.ok = 1'b1;
         p.px = curve_coord(ctrl[REG_CTRL0_X], ctrl[REG_CTRL1_X], ctrl[REG_CTRL2_X], s, n);
         p.py = curve_coord(ctrl[REG_CTRL0_Y], ctrl[REG_CTRL1_Y], ctrl[REG_CTRL2_Y], s, n);
      end
      return p;
   endfunction

   // check every strobed beat against the oldest expectation
   always @(posedge clock) begin
      point_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_point_x, rsp_point_y, rsp_step_total, rsp_in_range};
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", got);
         end else begin
            want = pending_points.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_W'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx < NUM_REGS) ctrl[idx] = val[CB-1:0];
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_points(input logic [CB-1:0] v[NUM_REGS]);
      drain();
      for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), {20'h0, v[i]});
   endtask

   // hold start until accepted; optional idle gap first
   task automatic send_sample(input logic [INDEX_W-1:0] s, input logic typed,
                              input point_type want);
      point_type p;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_sample_index <= s;
      do @(posedge clock); while (busy);
      p = sample_point(s);
      pending_points.push_back(typed ? want : p);
   endtask

   task automatic random_points(input int mode);
      logic [CB-1:0] v[NUM_REGS];
      for (int i = 0; i < NUM_REGS; i++)
         case (mode)
            0: v[i] = '1;
            1: v[i] = CB'($urandom_range(40));
            default: v[i] = CB'($urandom);
         endcase
      set_points(v);
   endtask

   initial begin
      row_type rows[$];
      logic [CB-1:0] v[NUM_REGS];
      point_type z;
      point_type first;
      int n;
      for (int i = 0; i < NUM_REGS; i++) ctrl[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      z = '0;
      // all points at the origin: no steps, every index out of range
      send_sample('0, 1'b1, z);
      send_sample('1, 1'b1, z);
      start <= 1'b0;
      // straight diagonal from origin to far corner
      v = '{12'd0, 12'd0, 12'd2048, 12'd2048, 12'hFFF, 12'hFFF};
      set_points(v);
      rows = '{
         '{14'd0,     1'b1, '{12'd0, 12'd0, 14'd16380, 1'b1}},
         '{14'd16379, 1'b0, z},
         '{14'd16380, 1'b1, '{12'd0, 12'd0, 14'd16380, 1'b0}},
         '{14'h3FFF,  1'b1, '{12'd0, 12'd0, 14'd16380, 1'b0}},
         '{14'd8190,  1'b0, z},
         '{14'h2AAA,  1'b0, z},
         '{14'h1555,  1'b0, z},
         '{14'd1,     1'b0, z}};
      foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].want);
      start <= 1'b0;
      // tiny curve, N = 2: middle index and rounding
      v = '{12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd0};
      set_points(v);
      for (int s = 0; s < 4; s++) send_sample(INDEX_W'(s), 1'b0, z);
      start <= 1'b0;
      // reversed endpoints, unknown register write ignored
      v = '{12'hFFF, 12'hFFF, 12'd5, 12'hFFF, 12'd0, 12'd0};
      set_points(v);
      write_reg(3'd7, 32'hFFFF_FFFF);
      write_reg(3'd6, 32'h0000_0123);
      send_sample(14'd0, 1'b1, '{12'hFFF, 12'hFFF, 14'd16380, 1'b1});
      send_sample(14'd100, 1'b0, z);
      start <= 1'b0;

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 64;
            2: idle_pct = 0;
            default: idle_pct = 31;
         endcase
         start <= 1'b0;
         random_points(phase == 5 ? 0 : (phase % 3 == 1 ? 1 : 2));
         first = sample_point('0);
         n = int'(first.steps);
         for (int k = 0; k < 250; k++) begin
            if (k == 125) begin
               // hold off until the pipe is empty
               start <= 1'b0;
               while (pending_points.size() != 0) @(posedge clock);
            end
            if ($urandom_range(9) == 0 || n == 0) send_sample(INDEX_W'($urandom), 1'b0, z);
            else send_sample(INDEX_W'($urandom_range(n - 1)), 1'b0, z);
         end
      end
      start <= 1'b0;
      drain();
      if (mismatches == 0 && pending_points.size() == 0)
         $display("PASS quadratic_curve_point_sampler_core");
      else
         $display("FAIL quadratic_curve_point_sampler_core");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL quadratic_curve_point_sampler_core");
      $finish;
   end

endmodule
